// ===== rtl/rmmq_pkg.sv =====
package rmmq_pkg;

  // Field widths of the item formats.
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned INDEX_W     = 10;
  localparam int unsigned RANGE_END_W = 11;
  localparam int unsigned USED_LEN_W  = 11;

  // Default store depth.
  localparam int unsigned DEF_MAX_ENTRIES = 1024;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] CFG_USED_LENGTH = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_MODE    = CFG_INDEX_W'(1);

  localparam logic [USED_LEN_W-1:0] USED_LENGTH_RST = USED_LEN_W'(2);
  localparam logic                  MAX_MODE_RST    = 1'b0;

  // Command codes of an input item.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                          command;
    logic [INDEX_W-1:0]            write_index;
    logic signed [VALUE_W-1:0]     write_value;
    logic [INDEX_W-1:0]            range_start;
    logic [RANGE_END_W-1:0]        range_end;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] answer_value;
    logic                      range_error;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;
    logic query_start;
    logic rd_en;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_query;
    logic query_err;
    logic last_read;
    logic out_free;
  } ctrl_status_t;

endpackage

// ===== rtl/rmmq_ctrl.sv =====
module rmmq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rmmq_pkg::ctrl_status_t status_i,
  output rmmq_pkg::ctrl_cmd_t    cmd_o
);

  rmmq_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmmq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rmmq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (status_i.in_is_query) begin
            cmd_o.query_start = 1'b1;
            state_d = status_i.query_err ? rmmq_pkg::ST_RESULT : rmmq_pkg::ST_SCAN;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      rmmq_pkg::ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (status_i.last_read) begin
          state_d = rmmq_pkg::ST_DRAIN;
        end
      end
      rmmq_pkg::ST_DRAIN: begin
        // The last read word is folded into the running extreme here.
        state_d = rmmq_pkg::ST_RESULT;
      end
      rmmq_pkg::ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = rmmq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rmmq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/rmmq_datapath.sv =====
module rmmq_datapath #(
  parameter int unsigned MAX_ENTRIES = rmmq_pkg::DEF_MAX_ENTRIES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rmmq_pkg::in_item_t                  in_item_i,
  input  logic                                cfg_we_i,
  input  logic [rmmq_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [rmmq_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  rmmq_pkg::ctrl_cmd_t                 cmd_i,
  output rmmq_pkg::ctrl_status_t              status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rmmq_pkg::out_item_t                 out_item_o
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned EW = rmmq_pkg::RANGE_END_W;

  logic [rmmq_pkg::USED_LEN_W-1:0]     used_length_q;
  logic                                max_mode_q;

  logic signed [rmmq_pkg::VALUE_W-1:0] store_q [MAX_ENTRIES];
  logic signed [rmmq_pkg::VALUE_W-1:0] rdata_q;
  logic                                rvalid_q;

  logic [EW-1:0]                       ptr_q;
  logic [EW-1:0]                       ptr_nxt;
  logic [EW-1:0]                       end_q;
  logic [EW-1:0]                       start_ext;
  logic signed [rmmq_pkg::VALUE_W-1:0] best_q;
  logic                                first_q;
  logic                                err_q;
  logic                                query_err;
  logic                                wr_in_range;
  logic                                better;
  logic                                out_valid_q;
  rmmq_pkg::out_item_t                 out_item_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_length_q <= rmmq_pkg::USED_LENGTH_RST;
      max_mode_q    <= rmmq_pkg::MAX_MODE_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == rmmq_pkg::CFG_USED_LENGTH) begin
        used_length_q <= cfg_data_i[rmmq_pkg::USED_LEN_W-1:0];
      end else if (cfg_index_i == rmmq_pkg::CFG_MAX_MODE) begin
        max_mode_q <= cfg_data_i[0];
      end
    end
  end

  // Range check: empty or reversed range, or end beyond the used length or the store.
  assign start_ext = {1'b0, in_item_i.range_start};
  assign query_err = (start_ext >= in_item_i.range_end) ||
                     (in_item_i.range_end > used_length_q) ||
                     (32'(in_item_i.range_end) > 32'(MAX_ENTRIES));

  assign wr_in_range = 32'(in_item_i.write_index) < 32'(MAX_ENTRIES);
  assign ptr_nxt     = ptr_q + EW'(1);

  // Value store with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_in_range) begin
      store_q[AW'(in_item_i.write_index)] <= in_item_i.write_value;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= store_q[AW'(ptr_q)];
    end
  end

  assign better = max_mode_q ? (rdata_q > best_q) : (rdata_q < best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
      first_q  <= 1'b0;
      err_q    <= 1'b0;
    end else begin
      rvalid_q <= cmd_i.rd_en;
      if (cmd_i.query_start) begin
        first_q <= 1'b1;
        err_q   <= query_err;
      end else if (rvalid_q) begin
        first_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_start) begin
      ptr_q <= start_ext;
      end_q <= in_item_i.range_end;
    end else if (cmd_i.rd_en) begin
      ptr_q <= ptr_nxt;
    end
    if (rvalid_q && (first_q || better)) begin
      best_q <= rdata_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_item_q.answer_value <= err_q ? '0 : best_q;
      out_item_q.range_error  <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign status_o.in_is_query = (in_item_i.command == rmmq_pkg::CMD_QUERY);
  assign status_o.query_err   = query_err;
  assign status_o.last_read   = (ptr_nxt == end_q);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/range_min_max_query.sv =====
// Write item: stored at the accepting clock edge, no result.
// Query item: the result is loaded into the output register after the scan, drain and
// result states, or after the result state alone when the range is rejected; a waiting result delays it.
// One item at a time: a query holds the block through its scan, drain and result states,
// only the result state when rejected; the scan is set by the store's single read port that reads one entry per cycle.
// Reset (rst_ni, async, active low) clears control state, sets used_length 2, max_mode 0.
module range_min_max_query #(
  parameter int unsigned MAX_ENTRIES = rmmq_pkg::DEF_MAX_ENTRIES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input item channel.
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  rmmq_pkg::in_item_t               in_item_i,
  // Result item channel.
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output rmmq_pkg::out_item_t              out_item_o,
  // Configuration write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rmmq_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [rmmq_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // The controller walks a query through scan, drain and result states; a rejected query goes straight to result.
  // The datapath holds the value store, the configuration registers, the
  // scan pointer, the running extreme and the output register.
  rmmq_pkg::ctrl_cmd_t    cmd;
  rmmq_pkg::ctrl_status_t status;

  // Configuration writes are always taken. The user must write only while the block
  // is idle, so they never race with a query in flight; the block itself does not enforce this.
  assign cfg_ready_o = 1'b1;

  rmmq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The scan reads one entry per cycle. The read data is registered, so the
  // comparison against the running extreme happens in the cycle after the read.
  // The output register lets a new item enter while a result still waits.
  rmmq_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/rmmq_checker.sv =====
module rmmq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input rmmq_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rmmq_pkg::out_item_t out_item_o
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed or dropped while stalled");

  // A rejected range reports zero.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.range_error |-> out_item_o.answer_value == '0)
    else $error("error result with nonzero value");

  // An accepted query occupies the block in the next cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.command == rmmq_pkg::CMD_QUERY)
    |=> !in_ready_o)
    else $error("input taken right after a query");

  // A new result appears only after the block was busy with a query.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a query in progress");

endmodule

bind range_min_max_query rmmq_checker u_rmmq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// ===== bench/tb_range_min_max_query.sv =====
module tb_range_min_max_query;
  timeunit 1ns;
  timeprecision 1ps;

  // Field widths of the item formats and the configuration port.
  localparam int VALUE_W     = rmmq_pkg::VALUE_W;
  localparam int INDEX_W     = rmmq_pkg::INDEX_W;
  localparam int RANGE_END_W = rmmq_pkg::RANGE_END_W;
  localparam int USED_LEN_W  = rmmq_pkg::USED_LEN_W;
  localparam int CFG_INDEX_W = rmmq_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W  = rmmq_pkg::CFG_DATA_W;

  // Depth of the value store, matching the default of the block.
  localparam int STORE_DEPTH = rmmq_pkg::DEF_MAX_ENTRIES;

  // Extreme values of a stored entry.
  localparam logic signed [VALUE_W-1:0] MOST_NEGATIVE = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] MOST_POSITIVE = {1'b0, {(VALUE_W-1){1'b1}}};

  // Register indexes past the end of the register list; writes there do nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_FIRST = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LAST  = '1;

  // A write item is stored at the edge that accepts it, so a short pause is
  // enough before touching the registers once the last answer is back.
  localparam int SETTLE_CYCLES = 4;
  // The longest query scans the whole store, then passes the drain and result states.
  localparam int DRAIN_CYCLES  = STORE_DEPTH + 16;
  localparam int TIMEOUT_NS    = 150_000_000;
  localparam int REPORT_LIMIT  = 10;
  // Share of random items that are writes, and share of queries that are
  // deliberately malformed (empty, reversed or too long a range).
  localparam int WRITE_PCT     = 40;
  localparam int MALFORMED_PCT = 15;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  rmmq_pkg::in_item_t   in_item_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  rmmq_pkg::out_item_t  out_item_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  range_min_max_query DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Our own copy of the block's state: the stored values, which entries have
  // been written since reset, and the two configuration registers.
  logic signed [VALUE_W-1:0] mirror_store [STORE_DEPTH];
  bit                        entry_written [STORE_DEPTH];
  logic [USED_LEN_W-1:0]     used_length_q;
  logic                      max_mode_q;

  // Answers predicted for accepted queries, oldest first.
  rmmq_pkg::out_item_t pending_answers [$];

  int unsigned items_sent;
  int unsigned writes_sent;
  int unsigned queries_sent;
  int unsigned rejected_queries;
  int unsigned results_checked;
  int unsigned fail_count;

  // Percent of cycles in which the sender holds back an item and the
  // receiver refuses a result.
  int send_idle_pct;
  int recv_idle_pct;

  always #5 clk_i = ~clk_i;

  // The receiver decides once per cycle, at the falling edge, whether it
  // takes a result at the next rising edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Each accepted result is compared with the oldest predicted answer.
  always @(posedge clk_i) begin : check_results
    rmmq_pkg::out_item_t wanted;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("Unexpected result at %0t: answer %0d error %0b", $realtime,
                   out_item_o.answer_value, out_item_o.range_error);
        end
      end else begin
        wanted = pending_answers.pop_front();
        results_checked++;
        if (out_item_o.answer_value !== wanted.answer_value ||
            out_item_o.range_error !== wanted.range_error) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("Mismatch at %0t: expected answer %0d error %0b, got answer %0d error %0b",
                     $realtime, wanted.answer_value, wanted.range_error,
                     out_item_o.answer_value, out_item_o.range_error);
          end
        end
      end
    end
  end

  // A used length above the store depth behaves as the store depth.
  function automatic int query_limit();
    return (used_length_q > STORE_DEPTH) ? STORE_DEPTH : int'(used_length_q);
  endfunction

  // Computes the answer to one query from the mirrored store and registers.
  function automatic rmmq_pkg::out_item_t predict_answer(input rmmq_pkg::in_item_t item);
    rmmq_pkg::out_item_t answer;
    logic signed [VALUE_W-1:0] best;
    int first;
    int stop;
    first = item.range_start;
    stop = item.range_end;
    answer.answer_value = '0;
    answer.range_error = 1'b1;
    if (first < stop && stop <= query_limit()) begin
      best = mirror_store[first];
      for (int i = first + 1; i < stop; i++) begin
        if (max_mode_q ? (mirror_store[i] > best) : (mirror_store[i] < best)) begin
          best = mirror_store[i];
        end
      end
      answer.answer_value = best;
      answer.range_error = 1'b0;
    end
    return answer;
  endfunction

  // Values lean toward the extremes and a few small numbers, so that ties
  // and the most negative and most positive entries show up often.
  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(9))
      0:       return MOST_NEGATIVE;
      1:       return MOST_POSITIVE;
      2:       return VALUE_W'(int'($urandom_range(3)) - 2);
      default: return VALUE_W'($urandom());
    endcase
  endfunction

  // The fields that a write does not use carry random noise.
  function automatic rmmq_pkg::in_item_t make_write(input int idx,
                                                    input logic signed [VALUE_W-1:0] value);
    rmmq_pkg::in_item_t item;
    item.command = rmmq_pkg::CMD_WRITE;
    item.write_index = INDEX_W'(idx);
    item.write_value = value;
    item.range_start = INDEX_W'($urandom());
    item.range_end = RANGE_END_W'($urandom());
    return item;
  endfunction

  // The fields that a query does not use carry random noise.
  function automatic rmmq_pkg::in_item_t make_query(input int first, input int stop);
    rmmq_pkg::in_item_t item;
    item.command = rmmq_pkg::CMD_QUERY;
    item.write_index = INDEX_W'($urandom());
    item.write_value = VALUE_W'($urandom());
    item.range_start = INDEX_W'(first);
    item.range_end = RANGE_END_W'(stop);
    return item;
  endfunction

  // Offers one item, waits for the handshake and then updates the mirrored
  // state. Valid stays high after acceptance until the next falling edge,
  // where the next call either replaces the item or idles.
  task automatic send_item(input rmmq_pkg::in_item_t item);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (item.command == rmmq_pkg::CMD_WRITE) begin
      mirror_store[item.write_index] = item.write_value;
      entry_written[item.write_index] = 1'b1;
      writes_sent++;
    end else begin
      pending_answers = {pending_answers, predict_answer(item)};
      if (pending_answers[$].range_error) begin
        rejected_queries++;
      end
      queries_sent++;
    end
  endtask

  // Writes one register and mirrors the write. Only called while idle.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == rmmq_pkg::CFG_USED_LENGTH) begin
      used_length_q = data[USED_LEN_W-1:0];
    end else if (idx == rmmq_pkg::CFG_MAX_MODE) begin
      max_mode_q = data[0];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stops offering items and waits until every predicted answer has come
  // back, then lets a trailing write settle.
  task automatic wait_for_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Sends one query. Most are well formed, with lengths that are mostly
  // short and now and then span the whole used length; any entry in such a
  // range that was never written is written first, so no query ever reads
  // an undefined entry. The rest are empty, reversed or too long.
  task automatic send_random_query();
    int lim;
    int len;
    int first;
    int stop;
    int r;
    lim = query_limit();
    if (lim == 0 || $urandom_range(99) < MALFORMED_PCT) begin
      if ($urandom_range(1) || lim >= 2047) begin
        first = $urandom_range(STORE_DEPTH - 1);
        stop = $urandom_range(first);
      end else begin
        first = $urandom_range(STORE_DEPTH - 1);
        stop = $urandom_range(2047, lim + 1);
      end
    end else begin
      r = $urandom_range(99);
      if (r < 70) begin
        len = $urandom_range(16, 1);
      end else if (r < 95) begin
        len = $urandom_range(128, 17);
      end else begin
        len = $urandom_range(STORE_DEPTH, 129);
      end
      if (len > lim) begin
        len = $urandom_range(lim, 1);
      end
      first = $urandom_range(lim - len);
      stop = first + len;
      for (int i = first; i < stop; i++) begin
        if (!entry_written[i]) begin
          send_item(make_write(i, random_value()));
        end
      end
    end
    send_item(make_query(first, stop));
  endtask

  // Writes both extremes, ties and mixed bit patterns into the first eight
  // entries, then asks minimum and maximum queries over them, including a
  // maximum over a single most negative entry and single-entry ranges.
  task automatic test_extreme_values();
    wait_for_idle();
    write_register(rmmq_pkg::CFG_USED_LENGTH, 32'd8);
    write_register(rmmq_pkg::CFG_MAX_MODE, 32'd0);
    send_item(make_write(0, MOST_NEGATIVE));
    send_item(make_write(1, MOST_POSITIVE));
    send_item(make_write(2, -32'sd1));
    send_item(make_write(3, 32'sd0));
    send_item(make_write(4, 32'sd1));
    send_item(make_write(5, MOST_NEGATIVE));
    send_item(make_write(6, 32'sh5555_5555));
    send_item(make_write(7, 32'shAAAA_AAAA));
    send_item(make_query(0, 8));
    send_item(make_query(1, 5));
    send_item(make_query(3, 4));
    wait_for_idle();
    write_register(rmmq_pkg::CFG_MAX_MODE, 32'd1);
    send_item(make_query(0, 8));
    send_item(make_query(5, 6));
    send_item(make_query(2, 5));
  endtask

  // Empty, reversed and too-long ranges, used lengths of zero and one,
  // writes to registers that do not exist, and register data whose upper
  // bits must be ignored.
  task automatic test_range_errors();
    send_item(make_query(3, 3));
    send_item(make_query(7, 2));
    send_item(make_query(0, 9));
    wait_for_idle();
    write_register(rmmq_pkg::CFG_USED_LENGTH, 32'd0);
    send_item(make_query(0, 1));
    wait_for_idle();
    write_register(rmmq_pkg::CFG_USED_LENGTH, 32'd1);
    send_item(make_query(0, 1));
    wait_for_idle();
    write_register(CFG_UNUSED_FIRST, 32'd0);
    write_register(CFG_UNUSED_LAST, 32'hFFFF_FFFF);
    send_item(make_query(0, 1));
    send_item(make_query(0, 2));
    wait_for_idle();
    // Only the low eleven bits count, so this sets a used length of four.
    write_register(rmmq_pkg::CFG_USED_LENGTH, 32'hFFFF_F804);
    send_item(make_query(0, 4));
    wait_for_idle();
    // Only the low bit counts, so this selects minimum mode.
    write_register(rmmq_pkg::CFG_MAX_MODE, 32'hFFFF_FFFE);
    send_item(make_query(0, 4));
  endtask

  // Random writes and queries under one idle profile, in phases that each
  // start from a fresh register setting: the full store in both modes, a
  // used length past the store, small and tiny lengths, and random ones.
  task automatic test_random_traffic(input int n_items, input int send_pct, input int recv_pct);
    int phase_items;
    int target;
    int len_cfg;
    int lim;
    int idx;
    bit mode_cfg;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    phase_items = n_items / 7;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          len_cfg = STORE_DEPTH;
          mode_cfg = 1'b0;
        end
        1: begin
          len_cfg = STORE_DEPTH;
          mode_cfg = 1'b1;
        end
        2: begin
          len_cfg = $urandom_range(1) ? 2047 : $urandom_range(2046, STORE_DEPTH + 1);
          mode_cfg = $urandom_range(1);
        end
        3: begin
          len_cfg = $urandom_range(STORE_DEPTH - 1, 2);
          mode_cfg = 1'b0;
        end
        4: begin
          len_cfg = 2;
          mode_cfg = 1'b1;
        end
        5: begin
          len_cfg = $urandom_range(1);
          mode_cfg = $urandom_range(1);
        end
        default: begin
          len_cfg = $urandom_range(STORE_DEPTH - 1, 2);
          mode_cfg = 1'b1;
        end
      endcase
      wait_for_idle();
      // Random upper bits check that only the register's own width is used.
      write_register(rmmq_pkg::CFG_USED_LENGTH, ($urandom() & ~32'h7FF) | 32'(len_cfg));
      write_register(rmmq_pkg::CFG_MAX_MODE, ($urandom() & ~32'h1) | 32'(mode_cfg));
      write_register(CFG_INDEX_W'($urandom_range(int'(CFG_UNUSED_LAST),
                                                 int'(CFG_UNUSED_FIRST))), $urandom());
      target = items_sent + phase_items;
      while (items_sent < target) begin
        if ($urandom_range(99) < WRITE_PCT) begin
          lim = query_limit();
          idx = (lim > 0 && $urandom_range(1)) ? $urandom_range(lim - 1)
                                                : $urandom_range(STORE_DEPTH - 1);
          send_item(make_write(idx, random_value()));
        end else begin
          send_random_query();
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    used_length_q = rmmq_pkg::USED_LENGTH_RST;
    max_mode_q = rmmq_pkg::MAX_MODE_RST;
    items_sent = 0;
    writes_sent = 0;
    queries_sent = 0;
    rejected_queries = 0;
    results_checked = 0;
    fail_count = 0;
    send_idle_pct = 7;
    recv_idle_pct = 52;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_extreme_values();
    test_range_errors();
    // Sender rarely idles while the receiver stalls about half the time,
    // then the other way round, then both run flat out.
    test_random_traffic(580, 7, 52);
    test_random_traffic(580, 52, 7);
    test_random_traffic(590, 0, 0);

    // Wait for the last answers, then long enough for a full-store scan so
    // that a stray extra result would still be caught.
    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Summary: %0d items sent, %0d writes and %0d queries (%0d rejected ranges).",
             items_sent, writes_sent, queries_sent, rejected_queries);
    $display("Summary: %0d results checked under min and max mode, %0d mismatches.",
             results_checked, fail_count);
    if (fail_count == 0 && pending_answers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes or an answer never comes.
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
